>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("%m: condition violated");

// consequent holds at the next edge after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: sequence violated");

`endif

>>> rtl/mcpbb_pkg.sv
// shared types and constants of the pressure regulator
package mcpbb_pkg;

   localparam int NUM_CHANNELS = 6;
   localparam int MASK_W       = 6;
   localparam int CHAN_W       = 3;
   localparam int PRES_W       = 16;
   localparam int SPEED_W      = 8;
   localparam int MAXP_W       = 15;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 15;

   localparam logic                RST_AUTO_PUMP     = 1'b1;
   localparam logic [SPEED_W-1:0]  RST_MANUAL_SPEED  = 8'd0;
   localparam logic [SPEED_W-1:0]  RST_SPEED_HIGH    = 8'd255;
   localparam logic [SPEED_W-1:0]  RST_SPEED_OFF     = 8'd0;
   localparam logic [SPEED_W-1:0]  RST_SPEED_DEFAULT = 8'd128;
   localparam logic [MAXP_W-1:0]   RST_MAX_PRESSURE  = 15'd2304;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_AUTO_PUMP     = 3'd0,
      REG_MANUAL_SPEED  = 3'd1,
      REG_SPEED_HIGH    = 3'd2,
      REG_SPEED_OFF     = 3'd3,
      REG_SPEED_DEFAULT = 3'd4,
      REG_MAX_PRESSURE  = 3'd5
   } csr_reg_type;

   localparam logic CMD_SET_TARGET = 1'b0;
   localparam logic CMD_TICK       = 1'b1;

   typedef struct packed {
      logic taken;
      logic fill;
      logic vent;
      logic hold;
      logic ckpt;
      logic infl;
      logic defl;
      logic serviced;
      logic pump_need;
   } lane_res_type;

   typedef struct packed {
      logic               accepted;
      logic [MASK_W-1:0]  fill;
      logic [MASK_W-1:0]  vent;
      logic [MASK_W-1:0]  hold;
      logic [MASK_W-1:0]  infl;
      logic [MASK_W-1:0]  defl;
      logic [MASK_W-1:0]  ckpt;
      logic [SPEED_W-1:0] pump_power;
      logic               pump_written;
      logic               serviced;
   } rsp_type;

endpackage

>>> rtl/mcpbb_lane.sv
// one channel: target store, inflate/deflate flags and valve decision
module mcpbb_lane import mcpbb_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic                     command,
   input  logic                     select,
   input  logic                     calibrated,
   input  logic                     motion_active,
   input  logic signed [PRES_W-1:0] target_clamped,
   input  logic signed [PRES_W-1:0] pressure,
   output lane_res_type             res
);

   logic                     infl_ff, infl_in;
   logic                     defl_ff, defl_in;
   logic signed [PRES_W-1:0] target_ff, target_in;

   always_comb begin
      res       = '0;
      infl_in   = infl_ff;
      defl_in   = defl_ff;
      target_in = target_ff;
      if (command == CMD_SET_TARGET) begin
         if (select) begin
            res.taken = 1'b1;
            target_in = target_clamped;
            if (pressure < target_clamped) begin
               infl_in  = 1'b1;
               defl_in  = 1'b0;
               res.fill = 1'b1;
            end else if (pressure > target_clamped) begin
               defl_in  = 1'b1;
               infl_in  = 1'b0;
               res.vent = 1'b1;
            end else begin
               res.hold = 1'b1;
               res.ckpt = motion_active;
            end
         end
      end else if (calibrated) begin
         if (infl_ff) begin
            res.serviced = 1'b1;
            if (pressure > target_ff) begin
               res.hold = 1'b1;
               res.ckpt = motion_active;
               infl_in  = 1'b0;
               defl_in  = 1'b0;
            end else begin
               res.pump_need = 1'b1;
            end
         end
         if (defl_in) begin
            res.serviced = 1'b1;
            if (pressure <= target_ff) begin
               res.hold = 1'b1;
               res.ckpt = motion_active;
               infl_in  = 1'b0;
               defl_in  = 1'b0;
            end
         end
      end
      res.infl = infl_in;
      res.defl = defl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         infl_ff   <= 1'b0;
         defl_ff   <= 1'b0;
         target_ff <= '0;
      end else if (accept) begin
         infl_ff   <= infl_in;
         defl_ff   <= defl_in;
         target_ff <= target_in;
      end
   end

endmodule

>>> rtl/mcpbb_merge.sv
// merges lane results into masks and runs the automatic pump level
module mcpbb_merge import mcpbb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               command,
   input  logic               auto_pump,
   input  logic [SPEED_W-1:0] manual_speed,
   input  logic [SPEED_W-1:0] speed_high,
   input  logic [SPEED_W-1:0] speed_off,
   input  lane_res_type       lanes [NUM_CHANNELS],
   output rsp_type            res
);

   logic [SPEED_W-1:0] level_ff, level_in;
   logic               taken_any;
   logic               serviced_any;
   logic               need_any;

   always_comb begin
      res          = '0;
      taken_any    = 1'b0;
      serviced_any = 1'b0;
      need_any     = 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         res.fill[i]  = lanes[i].fill;
         res.vent[i]  = lanes[i].vent;
         res.hold[i]  = lanes[i].hold;
         res.ckpt[i]  = lanes[i].ckpt;
         res.infl[i]  = lanes[i].infl;
         res.defl[i]  = lanes[i].defl;
         taken_any    = taken_any | lanes[i].taken;
         serviced_any = serviced_any | lanes[i].serviced;
         need_any     = need_any | lanes[i].pump_need;
      end
      level_in         = level_ff;
      res.pump_written = 1'b0;
      if (command == CMD_TICK && auto_pump) begin
         level_in         = need_any ? speed_high : speed_off;
         res.pump_written = 1'b1;
      end
      res.accepted   = (command == CMD_TICK) | taken_any;
      res.serviced   = (command == CMD_TICK) & serviced_any;
      res.pump_power = auto_pump ? level_in : manual_speed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= RST_SPEED_DEFAULT;
      end else if (accept) begin
         level_ff <= level_in;
      end
   end

endmodule

>>> rtl/multi_channel_pressure_bang_bang_top.sv
// top level of the six-channel on/off pressure regulator
// a result beat appears in the cycle after its request beat is taken
// throughput: one request beat per cycle; the output register holds one beat,
// and the request side stalls only while that beat is stalled
// reset: synchronous, active high; clears flags, targets and output valid,
// loads register defaults and the automatic pump level of 128
module multi_channel_pressure_bang_bang_top import mcpbb_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_write_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_command,
   input  logic [CHAN_W-1:0]        req_channel,
   input  logic signed [PRES_W-1:0] req_target_pressure,
   input  logic signed [PRES_W-1:0] req_pressure_a,
   input  logic signed [PRES_W-1:0] req_pressure_b,
   input  logic signed [PRES_W-1:0] req_pressure_c,
   input  logic signed [PRES_W-1:0] req_pressure_d,
   input  logic signed [PRES_W-1:0] req_pressure_e,
   input  logic signed [PRES_W-1:0] req_pressure_f,
   input  logic [MASK_W-1:0]        req_calibrated_mask,
   input  logic                     req_motion_active,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_accepted,
   output logic [MASK_W-1:0]        rsp_fill_mask,
   output logic [MASK_W-1:0]        rsp_vent_mask,
   output logic [MASK_W-1:0]        rsp_hold_mask,
   output logic [MASK_W-1:0]        rsp_inflating_mask,
   output logic [MASK_W-1:0]        rsp_deflating_mask,
   output logic [MASK_W-1:0]        rsp_checkpoint_clear_mask,
   output logic [SPEED_W-1:0]       rsp_pump_power,
   output logic                     rsp_pump_written,
   output logic                     rsp_serviced
);

   logic               auto_pump_ff;
   logic [SPEED_W-1:0] manual_speed_ff;
   logic [SPEED_W-1:0] speed_high_ff;
   logic [SPEED_W-1:0] speed_off_ff;
   logic [MAXP_W-1:0]  max_pressure_ff;

   logic                     accept;
   logic signed [PRES_W-1:0] max_signed;
   logic signed [PRES_W-1:0] target_clamped;
   logic signed [PRES_W-1:0] pressure [MASK_W];
   lane_res_type             lanes [NUM_CHANNELS];
   rsp_type                  merged;
   rsp_type                  out_ff;
   logic                     out_valid_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         auto_pump_ff     <= RST_AUTO_PUMP;
         manual_speed_ff  <= RST_MANUAL_SPEED;
         speed_high_ff    <= RST_SPEED_HIGH;
         speed_off_ff     <= RST_SPEED_OFF;
         max_pressure_ff  <= RST_MAX_PRESSURE;
      end else if (csr_write_enable) begin
         unique case (csr_reg_type'(csr_index))
            REG_AUTO_PUMP:     auto_pump_ff     <= csr_write_data[0];
            REG_MANUAL_SPEED:  manual_speed_ff  <= csr_write_data[SPEED_W-1:0];
            REG_SPEED_HIGH:    speed_high_ff    <= csr_write_data[SPEED_W-1:0];
            REG_SPEED_OFF:     speed_off_ff     <= csr_write_data[SPEED_W-1:0];
            // speed_default only seeds the level at reset
            REG_SPEED_DEFAULT: ;
            REG_MAX_PRESSURE:  max_pressure_ff  <= csr_write_data[MAXP_W-1:0];
            default: ;
         endcase
      end
   end

   assign accept    = req_valid & ~req_stall;
   assign req_stall = out_valid_ff & rsp_stall;

   // clamp to 0..max
   assign max_signed = signed'({1'b0, max_pressure_ff});
   always_comb begin
      target_clamped = req_target_pressure;
      if (req_target_pressure > max_signed) begin
         target_clamped = max_signed;
      end else if (req_target_pressure < 0) begin
         target_clamped = '0;
      end
   end

   assign pressure[0] = req_pressure_a;
   assign pressure[1] = req_pressure_b;
   assign pressure[2] = req_pressure_c;
   assign pressure[3] = req_pressure_d;
   assign pressure[4] = req_pressure_e;
   assign pressure[5] = req_pressure_f;

   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lane
      mcpbb_lane u_lane (
         .clock          (clock),
         .reset          (reset),
         .accept         (accept),
         .command        (req_command),
         .select         ((req_channel == CHAN_W'(i)) & req_calibrated_mask[i]),
         .calibrated     (req_calibrated_mask[i]),
         .motion_active  (req_motion_active),
         .target_clamped (target_clamped),
         .pressure       (pressure[i]),
         .res            (lanes[i])
      );
   end

   mcpbb_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .command      (req_command),
      .auto_pump    (auto_pump_ff),
      .manual_speed (manual_speed_ff),
      .speed_high   (speed_high_ff),
      .speed_off    (speed_off_ff),
      .lanes        (lanes),
      .res          (merged)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_ff <= merged;
      end
   end

   assign rsp_valid                 = out_valid_ff;
   assign rsp_accepted              = out_ff.accepted;
   assign rsp_fill_mask             = out_ff.fill;
   assign rsp_vent_mask             = out_ff.vent;
   assign rsp_hold_mask             = out_ff.hold;
   assign rsp_inflating_mask        = out_ff.infl;
   assign rsp_deflating_mask        = out_ff.defl;
   assign rsp_checkpoint_clear_mask = out_ff.ckpt;
   assign rsp_pump_power            = out_ff.pump_power;
   assign rsp_pump_written          = out_ff.pump_written;
   assign rsp_serviced              = out_ff.serviced;

endmodule

>>> rtl/mcpbb_checker.sv
// port-level checks of the pressure regulator, bound to the top level
`include "assert_macros.svh"

module mcpbb_checker import mcpbb_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic                     rsp_accepted,
   input logic [MASK_W-1:0]        rsp_fill_mask,
   input logic [MASK_W-1:0]        rsp_vent_mask,
   input logic [MASK_W-1:0]        rsp_hold_mask,
   input logic [MASK_W-1:0]        rsp_inflating_mask,
   input logic [MASK_W-1:0]        rsp_deflating_mask,
   input logic [MASK_W-1:0]        rsp_checkpoint_clear_mask,
   input logic [SPEED_W-1:0]       rsp_pump_power,
   input logic                     rsp_pump_written,
   input logic                     rsp_serviced
);

   // a channel never inflates and deflates at once
   `ASSERT_ALWAYS(a_flags_disjoint, clock, reset,
      !rsp_valid || ((rsp_inflating_mask & rsp_deflating_mask) == '0))

   // one valve action per channel in a beat
   `ASSERT_ALWAYS(a_valves_disjoint, clock, reset,
      !rsp_valid || (((rsp_fill_mask & rsp_vent_mask) | (rsp_fill_mask & rsp_hold_mask)
      | (rsp_vent_mask & rsp_hold_mask)) == '0))

   // a refused set-target beat moves no valve and writes no pump level
   `ASSERT_ALWAYS(a_refused_quiet, clock, reset,
      !(rsp_valid && !rsp_accepted) || ((rsp_fill_mask | rsp_vent_mask | rsp_hold_mask
      | rsp_checkpoint_clear_mask) == '0 && !rsp_pump_written && !rsp_serviced))

   // a taken request always yields a result beat next cycle
   `ASSERT_NEXT(a_req_to_rsp, clock, reset, req_valid && !req_stall, rsp_valid)

   // a stalled result beat holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_fill_mask) && $stable(rsp_pump_power))

endmodule

bind multi_channel_pressure_bang_bang_top mcpbb_checker u_mcpbb_checker (.*);
